// File: hdl/fbpa_pkg.sv
// Shared types and constants for the fixed-size block pool allocator.
// Payload structs, function codes and register indexes; no dependencies.
package fbpa_pkg;

  // Sub-pool geometry; POOL_BLOCKS must be a power of two.
  localparam int POOL_BLOCKS = 256;
  localparam int MAX_POOLS   = 16;

  localparam int HANDLE_W  = 12;
  localparam int LINK_DEPTH = 1 << HANDLE_W;
  localparam int SLOT_SH   = $clog2(POOL_BLOCKS);
  localparam int BUMP_W    = $clog2(POOL_BLOCKS + 1);
  localparam int POOLS_W   = $clog2(MAX_POOLS + 1);
  localparam int BPP_W     = 9;
  localparam int BSIZE_W   = 13;
  localparam int OFFSET_W  = 20;
  localparam int PADDR_W   = 3;

  // Function codes
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  // Register indexes (paddr word index)
  localparam logic REG_BLOCKS_PER_POOL = 1'b0;
  localparam logic REG_BLOCK_SIZE      = 1'b1;

  localparam logic [BPP_W-1:0]   BPP_RESET   = 9'd256;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd16;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] block_index;
  } in_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] alloc_index;
    logic [3:0]          sub_pool;
    logic [7:0]          slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic                from_free_list;
    logic                opened_pool;
  } out_t;

endpackage

// File: hdl/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator.
// Holds the next-link memory, allocator state and APB registers; uses fbpa_pkg.
//
// Each request (allocate, free, release all) yields exactly one result
// transfer. A request is taken into a holding register and then executed;
// the block takes no new request until the previous one has executed.
// Executing an allocate that pops the free list needs the link word of the
// current head; that registered read of the next-link memory is launched in
// the cycle the request is taken, ahead of its execute step. The result sits
// in an output register, so a request is taken
// while the previous result still waits for its consumer; execution stalls
// only while that output register stays full. Frees are not checked: any
// handle is pushed. Release all returns the allocator to its reset state
// (one empty sub-pool, empty free list) at once; link words need no clear
// because every entry on the free list is written before it is read.
// Registers: 0x0 blocks_per_pool (0 acts as 1, values above POOL_BLOCKS
// clamp), 0x4 block_size. Write them only while the block is idle.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Configuration registers
  logic [BPP_W-1:0]   bpp_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic               cfg_we;

  // Control state
  logic                state_q, state_d;
  logic [HANDLE_W-1:0] free_head_q, free_head_d;
  logic                free_ne_q, free_ne_d;
  logic [BUMP_W-1:0]   bump_q, bump_d;
  logic [POOLS_W-1:0]  pools_q, pools_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers
  in_t                 req_q;
  out_t                out_q, out_d;

  // Next-link memory: {more entries follow, next handle}
  logic [HANDLE_W:0]   link_mem [LINK_DEPTH];
  logic [HANDLE_W:0]   link_rd_q;
  logic                link_re, link_we;
  logic [HANDLE_W:0]   link_wdata;

  logic                in_xfer, out_free, exec;
  logic [BUMP_W-1:0]   limit;
  logic [POOLS_W-1:0]  pool_cur;
  logic [31:0]         bump_handle, open_handle;
  logic [HANDLE_W-1:0] pop_slot_full;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign exec     = (state_q == ST_EXEC) && out_free;

  // Launch the head's link read as the request arrives.
  assign link_re  = in_xfer && (in_data_i.func == FUNC_ALLOC) && free_ne_q;
  assign link_we  = exec && (req_q.func == FUNC_FREE);
  assign link_wdata = {free_ne_q, free_head_q};

  // ---------------------------------------------------------------
  // APB registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_RESET;
      bsize_q <= BSIZE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_BLOCKS_PER_POOL: bpp_q   <= pwdata[BPP_W-1:0];
        REG_BLOCK_SIZE:      bsize_q <= pwdata[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCKS_PER_POOL: prdata = 32'(bpp_q);
      REG_BLOCK_SIZE:      prdata = 32'(bsize_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Next-link memory, one write and one registered read port
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[req_q.block_index] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[free_head_q];
    end
  end

  // Hold the request for its execute cycle.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i;
    end
    if (exec) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------
  // Execute: clamp the slot limit, pick pop / bump / open / fail
  // ---------------------------------------------------------------
  always_comb begin
    if (bpp_q == '0) begin
      limit = BUMP_W'(1);
    end else if (32'(bpp_q) > 32'(POOL_BLOCKS)) begin
      limit = BUMP_W'(POOL_BLOCKS);
    end else begin
      limit = BUMP_W'(bpp_q);
    end
  end

  assign pool_cur      = pools_q - POOLS_W'(1);
  assign bump_handle   = 32'(pool_cur) * 32'(POOL_BLOCKS) + 32'(bump_q);
  assign open_handle   = 32'(pools_q) * 32'(POOL_BLOCKS);
  assign pop_slot_full = free_head_q & HANDLE_W'(POOL_BLOCKS - 1);

  always_comb begin
    free_head_d = free_head_q;
    free_ne_d   = free_ne_q;
    bump_d      = bump_q;
    pools_d     = pools_q;
    out_d       = '0;

    unique case (req_q.func)
      FUNC_ALLOC: begin
        if (free_ne_q) begin
          // pop the most recently freed handle
          free_ne_d   = link_rd_q[HANDLE_W];
          free_head_d = link_rd_q[HANDLE_W] ? link_rd_q[HANDLE_W-1:0] : '0;
          out_d.alloc_index    = free_head_q;
          out_d.sub_pool       = 4'(free_head_q >> SLOT_SH);
          out_d.slot           = pop_slot_full[7:0];
          out_d.byte_offset    = OFFSET_W'(32'(pop_slot_full) * 32'(bsize_q));
          out_d.from_free_list = 1'b1;
        end else if (bump_q < limit) begin
          bump_d = bump_q + BUMP_W'(1);
          out_d.alloc_index = bump_handle[HANDLE_W-1:0];
          out_d.sub_pool    = 4'(pool_cur);
          out_d.slot        = 8'(bump_q);
          out_d.byte_offset = OFFSET_W'(32'(bump_q) * 32'(bsize_q));
        end else if (32'(pools_q) < 32'(MAX_POOLS)) begin
          // open a new sub-pool, hand out its slot 0
          pools_d = pools_q + POOLS_W'(1);
          bump_d  = BUMP_W'(1);
          out_d.alloc_index = open_handle[HANDLE_W-1:0];
          out_d.sub_pool    = 4'(pools_q);
          out_d.opened_pool = 1'b1;
        end else begin
          out_d.status = 1'b1;
        end
      end
      FUNC_FREE: begin
        free_head_d = req_q.block_index;
        free_ne_d   = 1'b1;
      end
      FUNC_RELEASE: begin
        free_head_d = '0;
        free_ne_d   = 1'b0;
        bump_d      = '0;
        pools_d     = POOLS_W'(1);
      end
      FUNC_NOP: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencing and output register
  // ---------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: if (in_xfer) begin
        state_d = ST_EXEC;
      end
      ST_EXEC: if (out_free) begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      free_ne_q   <= 1'b0;
      bump_q      <= '0;
      pools_q     <= POOLS_W'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        free_head_q <= free_head_d;
        free_ne_q   <= free_ne_d;
        bump_q      <= bump_d;
        pools_q     <= pools_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/fixed_block_pool_allocator_test.sv
`timescale 1ns / 100ps
// Self-checking bench for fixed_block_pool_allocator: a directed table, then random
// alloc/free traffic under several pool geometries. Depends on fbpa_pkg and the RTL.
module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASES       = 8;
  localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 8;     // idle margin past the block and its output register

  typedef struct {
    in_t  req;
    bit   known;   // want holds a typed-in result; otherwise the predictor decides
    out_t want;
  } table_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Allocator image kept by the bench: LIFO of freed handles linked through
  // link_mem, bump counter of the newest sub-pool and the number of open pools.
  logic [HANDLE_W-1:0] lifo_top;
  bit                  lifo_live;
  logic [HANDLE_W-1:0] link_mem  [LINK_DEPTH];
  bit                  link_more [LINK_DEPTH];
  int                  fill_slot;
  int                  pool_count;
  logic [BPP_W-1:0]    cfg_bpp;
  logic [BSIZE_W-1:0]  cfg_bsize;

  out_t                pending_grants [$];   // results owed by the block, oldest first
  logic [HANDLE_W-1:0] held_blocks [$];      // handles handed out and not yet freed
  logic [HANDLE_W-1:0] last_freed = '0;
  int                  errors       = 0;
  int                  burst_left   = 0;
  int                  stall_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fixed_block_pool_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Drop back to one empty sub-pool and an empty free list (reset and release all).
  function automatic void clear_allocator();
    lifo_top   = '0;
    lifo_live  = 1'b0;
    fill_slot  = 0;
    pool_count = 1;
  endfunction

  // Advance the allocator image by one request and return the result it owes.
  function automatic out_t compute_grant(in_t req);
    out_t        g;
    int          lim;
    int          pool;
    int          slot;
    bit          more;
    logic [31:0] full;
    logic [31:0] off;
    g    = '0;
    pool = 0;
    slot = 0;
    case (req.func)
      FUNC_ALLOC: begin
        // Zero acts as one block, anything above POOL_BLOCKS clamps.
        lim = (cfg_bpp == 0) ? 1 : ((cfg_bpp > POOL_BLOCKS) ? POOL_BLOCKS : cfg_bpp);
        if (lifo_live) begin
          pool      = lifo_top / POOL_BLOCKS;
          slot      = lifo_top % POOL_BLOCKS;
          more      = link_more[lifo_top];
          lifo_top  = more ? link_mem[lifo_top] : '0;
          lifo_live = more;
          g.from_free_list = 1'b1;
        end else if (fill_slot < lim) begin
          // A bump slot left above a lowered limit falls through as a full pool.
          pool = pool_count - 1;
          slot = fill_slot;
          fill_slot++;
        end else if (pool_count < MAX_POOLS) begin
          pool = pool_count;
          slot = 0;
          pool_count++;
          fill_slot = 1;
          g.opened_pool = 1'b1;
        end else begin
          // Exhausted: report failure, leave every field zero and the state as is.
          g.status = 1'b1;
        end
        if (!g.status) begin
          full          = pool * POOL_BLOCKS + slot;
          off           = slot * cfg_bsize;
          g.alloc_index = full[HANDLE_W-1:0];
          g.sub_pool    = full[HANDLE_W-1:SLOT_SH];
          g.slot        = full[SLOT_SH-1:0];
          g.byte_offset = off[OFFSET_W-1:0];
        end
      end
      FUNC_FREE: begin
        // No check at all: push whatever handle arrives.
        link_mem[req.block_index]  = lifo_top;
        link_more[req.block_index] = lifo_live;
        lifo_top  = req.block_index;
        lifo_live = 1'b1;
      end
      FUNC_RELEASE: clear_allocator();
      default: ;  // unused code: nothing changes, status 0
    endcase
    return g;
  endfunction

  function automatic out_t mk_grant(int st, int idx, int pool, int slot, int off,
                                    int recycled, int opened);
    out_t g;
    g.status         = 1'(st);
    g.alloc_index    = HANDLE_W'(idx);
    g.sub_pool       = 4'(pool);
    g.slot           = 8'(slot);
    g.byte_offset    = OFFSET_W'(off);
    g.from_free_list = 1'(recycled);
    g.opened_pool    = 1'(opened);
    return g;
  endfunction

  function automatic table_row_t table_row(logic [1:0] func, int idx, int known, out_t want);
    table_row_t r;
    r.req.func        = func;
    r.req.block_index = HANDLE_W'(idx);
    r.known           = (known != 0);
    r.want            = want;
    return r;
  endfunction

  // Random request. Most traffic is alloc and free of live handles; the rest is
  // stray handles, double frees, unused codes and an occasional release all.
  function automatic in_t pick_request(int alloc_pct);
    in_t req;
    int  roll;
    int  k;
    req.block_index = HANDLE_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.func = FUNC_ALLOC;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        req.func = FUNC_FREE;
        if (held_blocks.size() > 0) begin
          k = $urandom_range(0, held_blocks.size() - 1);
          req.block_index = held_blocks[k];
          held_blocks.delete(k);
        end
      end else if (roll < 80) begin
        req.func = FUNC_FREE;
      end else if (roll < 90) begin
        req.func        = FUNC_FREE;
        req.block_index = last_freed;
      end else if (roll < 96) begin
        req.func = FUNC_NOP;
      end else begin
        req.func = FUNC_RELEASE;
      end
    end
    if (req.func == FUNC_FREE) last_freed = req.block_index;
    return req;
  endfunction

  // Present one request, hold it until the transfer, then record what it owes.
  // Between bursts drop valid for a random gap.
  task automatic issue(input in_t req, input bit known, input out_t typed);
    out_t grant;
    int   gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    grant = compute_grant(req);
    pending_grants.push_back(known ? typed : grant);
    if (req.func == FUNC_ALLOC && !grant.status) held_blocks.push_back(grant.alloc_index);
    if (req.func == FUNC_RELEASE) held_blocks.delete();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // Now and then a long stretch with no gaps at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Drain every owed result, then let the pipeline idle for the drain margin.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup, then access until pready, then idle;
  // mirror it in the image.
  task automatic apb_write(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (reg_sel == REG_BLOCKS_PER_POOL) cfg_bpp = value[BPP_W-1:0];
    else cfg_bsize = value[BSIZE_W-1:0];
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, out_data_o);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("alloc_index", 32'(want.alloc_index), 32'(out_data_o.alloc_index));
        check_field("sub_pool", 32'(want.sub_pool), 32'(out_data_o.sub_pool));
        check_field("slot", 32'(want.slot), 32'(out_data_o.slot));
        check_field("byte_offset", 32'(want.byte_offset), 32'(out_data_o.byte_offset));
        check_field("from_free_list", 32'(want.from_free_list),
                    32'(out_data_o.from_free_list));
        check_field("opened_pool", 32'(want.opened_pool), 32'(out_data_o.opened_pool));
      end
    end
  end

  // End the run once nothing has moved on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result consumer: switch among always-ready, random, mostly-ready, sparse
  // and long periodic stalls, each held for a random span.
  initial begin : sink_pacing
    int mode;
    int span;
    int tick;
    out_ready_i = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 7) != 0);
          3: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((tick % 24) >= 18);
        endcase
      end
    end
  end

  initial begin : stimulus
    table_row_t rows [$];
    int         phase_bpp   [PHASES];
    int         phase_bsize [PHASES];
    int         phase_alloc [PHASES];
    int         p;
    int         n;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    clear_allocator();
    cfg_bpp   = BPP_RESET;
    cfg_bsize = BSIZE_RESET;

    // Geometry per phase: single-block pools, tiny pools, the full 256, zero and
    // an oversized count (both clamp), block sizes at the edges and past the
    // offset width. No release between phases, so a lowered count can leave the
    // bump slot above the new limit.
    phase_bpp   = '{1, 2, 256, 0, 511, 3, 0, 1};
    phase_bsize = '{8, 4096, 8191, 0, 8, 0, 0, 4095};
    phase_alloc = '{75, 60, 55, 70, 80, 65, 55, 85};
    phase_bpp[6]   = $urandom_range(4, 40);
    phase_bsize[5] = $urandom_range(8, 4096);
    phase_bsize[6] = $urandom_range(0, 8191);

    // Directed table under the reset geometry (256 blocks of 16 bytes).
    rows.push_back(table_row(FUNC_ALLOC, 0, 1, mk_grant(0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(table_row(FUNC_ALLOC, 4095, 1, mk_grant(0, 1, 0, 1, 16, 0, 0)));
    rows.push_back(table_row(FUNC_FREE, 4095, 1, '0));  // never allocated
    rows.push_back(table_row(FUNC_ALLOC, 0, 1, mk_grant(0, 4095, 15, 255, 4080, 1, 0)));
    rows.push_back(table_row(FUNC_NOP, 4095, 1, '0));
    rows.push_back(table_row(FUNC_FREE, 0, 1, '0));
    rows.push_back(table_row(FUNC_FREE, 0, 1, '0));     // double free
    rows.push_back(table_row(FUNC_ALLOC, 0, 0, '0));
    rows.push_back(table_row(FUNC_ALLOC, 4095, 0, '0));
    rows.push_back(table_row(FUNC_ALLOC, 0, 0, '0));
    rows.push_back(table_row(FUNC_FREE, 12'hAAA, 1, '0));
    rows.push_back(table_row(FUNC_FREE, 12'h555, 1, '0));
    rows.push_back(table_row(FUNC_ALLOC, 0, 0, '0));
    rows.push_back(table_row(FUNC_ALLOC, 0, 0, '0));
    rows.push_back(table_row(FUNC_RELEASE, 4095, 1, '0));
    rows.push_back(table_row(FUNC_ALLOC, 0, 1, mk_grant(0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(table_row(FUNC_FREE, 3, 1, '0));
    rows.push_back(table_row(FUNC_RELEASE, 0, 1, '0));  // drops a non-empty list
    rows.push_back(table_row(FUNC_ALLOC, 0, 0, '0));
    rows.push_back(table_row(FUNC_NOP, 0, 1, '0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i].req, rows[i].known, rows[i].want);

    for (p = 0; p < PHASES; p++) begin
      // Reconfigure only with nothing in flight.
      settle();
      apb_write(REG_BLOCKS_PER_POOL, phase_bpp[p]);
      apb_write(REG_BLOCK_SIZE, phase_bsize[p]);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) issue(pick_request(phase_alloc[p]), 1'b0, '0);
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/fbpa_pkg.sv
hdl/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_test.sv
